/* design/block_mean_downscale_3x3_macros.svh */
// Assertion macros for the 3x3 block-mean downscaler.
`ifndef BLOCK_MEAN_DOWNSCALE_3X3_MACROS_SVH
`define BLOCK_MEAN_DOWNSCALE_3X3_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BMD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bmd_pkg.sv */
// Shared types, constants and helpers of the 3x3 block-mean downscaler.
`default_nettype none
package bmd_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	localparam logic [CFG_DATA_W-1:0] MIN_DIM    = 11'd3;
	localparam logic [CFG_DATA_W-1:0] MAX_HEIGHT = 11'd1024;
	localparam int ROW_W  = 10;   // row index 0..1023
	localparam int BROW_W = 9;    // block row index 0..341

	// 2^16/3 rounded up; exact floor(v/3) for any 11-bit v
	localparam logic [14:0] RECIP3 = 15'd21846;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_MID,
		PH_LAST
	} phase_t;

	// per-pixel control that travels from the scanner to the accumulator
	typedef struct packed {
		logic wr;     // pixel closes a group row: update column store
		logic first;  // top row of a block band: overwrite, do not add
		logic emit;   // bottom-right pixel of a full block
		logic last;   // final block of the frame
	} pix_ctl_t;

	typedef struct packed {
		logic valid;
		logic emit;
	} s1_stat_t;

	function automatic phase_t next_phase(input phase_t ph);
		phase_t nx;
		unique case (ph)
			PH_FIRST: nx = PH_MID;
			PH_MID:   nx = PH_LAST;
			default:  nx = PH_FIRST;
		endcase
		return nx;
	endfunction

	function automatic logic [9:0] div3(input logic [CFG_DATA_W-1:0] v);
		logic [25:0] p;
		p = 26'(v) * 26'(RECIP3);
		return p[25:16];
	endfunction

endpackage
`default_nettype wire

/* design/bmd_scan.sv */
// Frame scanner: size registers, raster counters and the in-group row sum.
`default_nettype none
module bmd_scan #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 5,
	localparam int GROUP_COUNT = MAX_WIDTH / 3,
	localparam int AW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1,
	localparam int RSW = PIXEL_BITS + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                         in_accept,
	input  logic [PIXEL_BITS-1:0]        pixel,
	output bmd_pkg::pix_ctl_t            ctl,
	output logic [AW-1:0]                addr,
	output logic [RSW-1:0]               row_total
);
	import bmd_pkg::*;

	localparam int WMAX = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
	localparam int CW = $clog2(WMAX);
	localparam int GW = $clog2(GROUP_COUNT + 1);
	localparam logic [CFG_DATA_W-1:0] WMAX_V = CFG_DATA_W'(WMAX);

	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [GW-1:0]         groups_q, grp_q;
	logic [BROW_W-1:0]     brows_q, brow_q;
	logic [CW-1:0]         col_q;
	logic [ROW_W-1:0]      row_q;
	phase_t                colph_q, rowph_q;
	logic [RSW-1:0]        rsum_q;

	logic [CFG_DATA_W-1:0] w_clamp, h_clamp;
	logic                  in_region, col_wrap, row_wrap;

	always_comb begin
		priority if (cfg_data < MIN_DIM) w_clamp = MIN_DIM;
		else if (cfg_data > WMAX_V)      w_clamp = WMAX_V;
		else                             w_clamp = cfg_data;
		priority if (cfg_data < MIN_DIM)  h_clamp = MIN_DIM;
		else if (cfg_data > MAX_HEIGHT)   h_clamp = MAX_HEIGHT;
		else                              h_clamp = cfg_data;
	end

	assign in_region = (grp_q < groups_q) && (brow_q < brows_q);
	assign col_wrap  = CFG_DATA_W'(col_q) == (width_q - 11'd1);
	assign row_wrap  = CFG_DATA_W'(row_q) == (height_q - 11'd1);
	assign row_total = rsum_q + RSW'(pixel);
	assign addr      = grp_q[AW-1:0];

	always_comb begin
		ctl.wr    = in_region && (colph_q == PH_LAST);
		ctl.first = rowph_q == PH_FIRST;
		ctl.emit  = ctl.wr && (rowph_q == PH_LAST);
		ctl.last  = (grp_q == GW'(groups_q - 1'b1)) && (brow_q == BROW_W'(brows_q - 1'b1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MIN_DIM;
			height_q <= MIN_DIM;
			groups_q <= GW'(1);
			brows_q  <= BROW_W'(1);
			col_q    <= '0;
			colph_q  <= PH_FIRST;
			grp_q    <= '0;
			row_q    <= '0;
			rowph_q  <= PH_FIRST;
			brow_q   <= '0;
			rsum_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					width_q  <= w_clamp;
					groups_q <= GW'(div3(w_clamp));
				end
				REG_HEIGHT: begin
					height_q <= h_clamp;
					brows_q  <= BROW_W'(div3(h_clamp));
				end
				default: ;
			endcase
			// any register write restarts the frame
			col_q   <= '0;
			colph_q <= PH_FIRST;
			grp_q   <= '0;
			row_q   <= '0;
			rowph_q <= PH_FIRST;
			brow_q  <= '0;
			rsum_q  <= '0;
		end else if (in_accept) begin
			if (in_region) begin
				rsum_q <= (colph_q == PH_LAST) ? '0 : row_total;
			end
			if (col_wrap) begin
				col_q   <= '0;
				colph_q <= PH_FIRST;
				grp_q   <= '0;
				if (row_wrap) begin
					row_q   <= '0;
					rowph_q <= PH_FIRST;
					brow_q  <= '0;
				end else begin
					row_q   <= row_q + 1'b1;
					rowph_q <= next_phase(rowph_q);
					if (rowph_q == PH_LAST) begin
						brow_q <= brow_q + 1'b1;
					end
				end
			end else begin
				col_q   <= col_q + 1'b1;
				colph_q <= next_phase(colph_q);
				if (colph_q == PH_LAST) begin
					grp_q <= grp_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* design/bmd_accum.sv */
// Column-group store, block sum, divide by nine and result register.
`default_nettype none
module bmd_accum #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 5,
	localparam int GROUP_COUNT = MAX_WIDTH / 3,
	localparam int AW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1,
	localparam int RSW = PIXEL_BITS + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_accept,
	input  bmd_pkg::pix_ctl_t      ctl,
	input  logic [AW-1:0]          addr,
	input  logic [RSW-1:0]         row_total,
	input  logic                   out_stall,
	output logic                   in_stall,
	output bmd_pkg::s1_stat_t      s1_stat,
	output logic                   out_valid,
	output logic [PIXEL_BITS-1:0]  block_mean,
	output logic                   frame_last
);
	import bmd_pkg::*;

	localparam int SUM_W = PIXEL_BITS + 4;   // nine pixels
	localparam int N     = SUM_W + 1;        // sum + 4
	localparam int K     = N + 4;
	localparam int MW    = K - 2;
	localparam int M     = (2 ** K + 8) / 9; // ceil(2^K / 9)
	localparam int PW    = N + MW;

	logic [SUM_W-1:0] mem [GROUP_COUNT];

	logic             valid_s1;
	pix_ctl_t         ctl_s1;
	logic [AW-1:0]    addr_s1;
	logic [RSW-1:0]   rtot_s1;
	logic [SUM_W-1:0] rd_s1;

	logic                  out_valid_q, last_q;
	logic [PIXEL_BITS-1:0] mean_q;

	logic             out_free, s1_adv;
	logic [SUM_W-1:0] sum_s1;
	logic [N-1:0]     biased;
	logic [PW-1:0]    prod;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// top row of a band overwrites, so the store never needs clearing
	assign sum_s1 = ctl_s1.first ? SUM_W'(rtot_s1) : rd_s1 + SUM_W'(rtot_s1);
	assign biased = N'(sum_s1) + N'(4);
	assign prod   = PW'(biased) * PW'(MW'(M));

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rd_s1 <= mem[addr];
		end
		if (s1_adv && ctl_s1.wr && !ctl_s1.emit) begin
			mem[addr_s1] <= sum_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ctl_s1  <= ctl;
			addr_s1 <= addr;
			rtot_s1 <= row_total;
		end
		if (s1_adv && ctl_s1.emit) begin
			mean_q <= prod[K +: PIXEL_BITS];
			last_q <= ctl_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !out_free);
			if (out_free) begin
				out_valid_q <= valid_s1 && ctl_s1.emit;
			end
		end
	end

	assign s1_stat.valid = valid_s1;
	assign s1_stat.emit  = ctl_s1.emit;
	assign out_valid     = out_valid_q;
	assign block_mean    = mean_q;
	assign frame_last    = last_q;

endmodule
`default_nettype wire

/* design/block_mean_downscale_3x3.sv */
// A block mean passes from its closing pixel transaction through the stage 1 register, then the
// result register, where it is held for the sink.
// Throughput: one pixel transaction per cycle; input stalls only while a result waits in a stalled
// result register and stage 1 is also full. Output frame is floor(height/3) by floor(width/3).
// Reset (arst_n low, async): width = height = 3, frame position and pipeline cleared.
// The column store is never cleared: the top row of each block band overwrites its entry.
`default_nettype none
module block_mean_downscale_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [PIXEL_BITS-1:0]          pixel,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [PIXEL_BITS-1:0]          block_mean,
	output logic                           frame_last
);
	import bmd_pkg::*;

	localparam int GROUP_COUNT = MAX_WIDTH / 3;
	localparam int AW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int RSW = PIXEL_BITS + 2;

	logic           in_accept, cfg_we;
	pix_ctl_t       ctl;
	logic [AW-1:0]  addr;
	logic [RSW-1:0] row_total;
	s1_stat_t       s1_stat;

	// size registers take a write in any cycle
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign in_accept = in_valid && !in_stall;

	// raster position, group and band counters, running row sum
	bmd_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.pixel     (pixel),
		.ctl       (ctl),
		.addr      (addr),
		.row_total (row_total)
	);

	// stage 1: column store read-modify-write and divide by nine;
	// then the result register, which lets input flow while a result waits
	bmd_accum #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.ctl        (ctl),
		.addr       (addr),
		.row_total  (row_total),
		.out_stall  (out_stall),
		.in_stall   (in_stall),
		.s1_stat    (s1_stat),
		.out_valid  (out_valid),
		.block_mean (block_mean),
		.frame_last (frame_last)
	);

`include "block_mean_downscale_3x3_macros.svh"

	`BMD_ASSERT_NOW(a_stall_needs_full, in_stall, out_valid && s1_stat.valid, "input stalled while result path has room")
	`BMD_ASSERT_NEXT(a_emit_reaches_s1, in_accept && ctl.emit, s1_stat.valid && s1_stat.emit, "block-closing pixel lost before stage 1")
	`BMD_ASSERT_NOW(a_result_from_s1, $rose(out_valid), $past(s1_stat.valid && s1_stat.emit), "result appeared without an emitting stage-1 item")

endmodule
`default_nettype wire
